// File: hdl/ipat_pkg.sv
// Shared widths, character codes and parser state type for the IP address text parser.
`timescale 1ns / 1ps

package ipat_pkg;

    localparam int MAX_ADDR_BYTES = 16;
    localparam int V4_BYTES       = 4;
    localparam int CHAR_W         = 8;
    localparam int BYTE_W         = 8;
    localparam int IDX_W          = $clog2(MAX_ADDR_BYTES);
    localparam int POS_W          = $clog2(MAX_ADDR_BYTES);
    localparam int CNT_W          = $clog2(MAX_ADDR_BYTES + 1);
    localparam int ADDR_W         = MAX_ADDR_BYTES * BYTE_W;
    localparam int V4_W           = V4_BYTES * BYTE_W;
    localparam int GROUP_W        = 16;
    localparam int DEC_W          = 8;
    localparam int DEC_MUL_W      = 12;

    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = APB_AW - 2;

    localparam logic [REG_IDX_W-1:0] REG_ACCEPT_IPV6 = '0;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3a;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
    localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;

    localparam logic [DEC_MUL_W-1:0] DEC_MAX = 12'd255;

    // Colon count only matters as zero, one, or two and more.
    localparam logic [1:0] COLON_SAT = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0]  bytes;
        logic [GROUP_W-1:0] group;
        logic [DEC_W-1:0]   dec;
        logic               dec_bad;
        logic [CNT_W-1:0]   bw;
        logic [1:0]         colons;
        logic [POS_W-1:0]   dc_pos;
        logic               dc_seen;
        logic               prev_colon;
        logic               v6;
        logic               mapped;
        logic [POS_W-1:0]   v4_pos;
        logic               suffix;
        logic               err;
    } t_parse_state;

endpackage

// File: hdl/ipat_in_if.sv
// Character input channel: valid/ready handshake with one text character per transfer.
`timescale 1ns / 1ps

interface ipat_in_if;
    logic                        valid;
    logic                        ready;
    logic [ipat_pkg::CHAR_W-1:0] text_char;
    logic                        in_last;

    modport source (output valid, output text_char, output in_last, input ready);
    modport sink   (input valid, input text_char, input in_last, output ready);
endinterface

// File: hdl/ipat_out_if.sv
// Result output channel: valid/ready handshake with one address byte per transfer.
`timescale 1ns / 1ps

interface ipat_out_if;
    logic                        valid;
    logic                        ready;
    logic [ipat_pkg::BYTE_W-1:0] out_byte;
    logic [ipat_pkg::IDX_W-1:0]  byte_index;
    logic                        is_ipv6;
    logic                        bad_address;
    logic                        out_last;

    modport source (output valid, output out_byte, output byte_index, output is_ipv6,
                    output bad_address, output out_last, input ready);
    modport sink   (input valid, input out_byte, input byte_index, input is_ipv6,
                    input bad_address, input out_last, output ready);
endinterface

// File: hdl/ip_address_text_parser.sv
// Flow: the final character's transfer loads a snapshot register; once the frame is free, the
// snapshot is finished into the result frame register, which offers the first result.
// Throughput: one character per cycle; results leave the frame shift register one per cycle
// while the receiver is ready (4 or 16 for an address, 1 for an error). Characters wait only
// while a finished snapshot is held as the previous string's results still leave the frame.
// Reset (synchronous, active low) clears the parser, drops pending results, sets accept_ipv6.
`timescale 1ns / 1ps

module ip_address_text_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ipat_in_if.sink                     i_in,
    ipat_out_if.source                  o_out,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [ipat_pkg::APB_AW-1:0] i_paddr,
    input  logic [ipat_pkg::APB_DW-1:0] i_pwdata,
    output logic [ipat_pkg::APB_DW-1:0] o_prdata,
    output logic                        o_pready
);
    import ipat_pkg::*;

    logic                 r_accept_ipv6;
    t_parse_state         r_live;
    t_parse_state         n_live;
    t_parse_state         r_snap;
    logic                 r_snap_valid;
    logic                 r_frame_valid;
    logic [ADDR_W-1:0]    r_frame_bytes;
    logic [IDX_W-1:0]     r_out_idx;
    logic                 r_out_v6;
    logic                 r_out_bad;

    logic                 in_xfer;
    logic                 out_xfer;
    logic                 out_done;
    logic                 frame_load;
    logic                 cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;

    logic [ADDR_W-1:0]    fin_bytes;
    logic                 fin_bad;

    function automatic logic [ADDR_W-1:0] put_byte(input logic [ADDR_W-1:0] v,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic [BYTE_W-1:0] b);
        logic [ADDR_W-1:0] wide;
        wide = ADDR_W'(b);
        // Positions at and above the fill count are still zero within a string.
        return v | (wide << (BYTE_W * pos));
    endfunction

    // ---------------- configuration port ----------------
    assign o_pready  = 1'b1;
    assign reg_idx   = i_paddr[APB_AW-1:2];
    assign cfg_write = i_psel && i_penable && i_pwrite && o_pready;
    assign o_prdata  = (reg_idx == REG_ACCEPT_IPV6) ? APB_DW'(r_accept_ipv6) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_ipv6 <= 1'b1;
        end else if (cfg_write && reg_idx == REG_ACCEPT_IPV6) begin
            r_accept_ipv6 <= i_pwdata[0];
        end
    end

    // ---------------- per-character parse ----------------
    assign i_in.ready = !r_snap_valid || frame_load;
    assign in_xfer    = i_in.valid && i_in.ready;

    always_comb begin
        logic [CHAR_W-1:0]    c;
        logic                 is_digit;
        logic                 is_letter;
        logic [3:0]           d;
        logic [GROUP_W-1:0]   grp_shift;
        logic                 grp_over;
        logic [DEC_MUL_W-1:0] dec_mul;
        logic [POS_W-1:0]     pos;

        n_live    = r_live;
        c         = i_in.text_char;
        is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
        is_letter = ((c >= CH_LO_A) && (c <= CH_LO_F)) || ((c >= CH_UP_A) && (c <= CH_UP_F));
        // Both letter cases have their value one below the low nibble plus ten.
        d         = is_digit ? c[3:0] : c[3:0] + 4'd9;
        grp_shift = {r_live.group[GROUP_W-5:0], d};
        grp_over  = (r_live.group[GROUP_W-1:GROUP_W-4] != 4'd0);
        dec_mul   = {1'b0, r_live.dec, 3'b000} + {3'b000, r_live.dec, 1'b0}
                  + DEC_MUL_W'(d);
        pos       = r_live.bw[POS_W-1:0];

        if (r_live.err) begin
            n_live.err = 1'b1;
        end else if (r_live.suffix) begin
            if (!is_digit) begin
                n_live.err = 1'b1;
            end
        end else if (r_live.bw[CNT_W-1]) begin
            n_live.err = 1'b1;
        end else if (is_digit || is_letter) begin
            n_live.prev_colon = 1'b0;
            if (r_live.mapped && is_letter) begin
                n_live.err = 1'b1;
            end else if (!r_live.mapped && grp_over) begin
                n_live.err = 1'b1;
            end else begin
                if (!r_live.mapped) begin
                    n_live.group = grp_shift;
                end
                if (is_letter) begin
                    n_live.dec_bad = 1'b1;
                end else if (!r_live.dec_bad) begin
                    if (dec_mul > DEC_MAX) begin
                        n_live.dec_bad = 1'b1;
                    end else begin
                        n_live.dec = dec_mul[DEC_W-1:0];
                    end
                end
            end
        end else begin
            unique case (c)
                CH_COLON: begin
                    if (r_live.mapped) begin
                        n_live.err = 1'b1;
                    end else if (!r_live.v6 && (r_live.bw != '0 || !r_accept_ipv6)) begin
                        n_live.err = 1'b1;
                    end else if (r_live.prev_colon && r_live.dc_seen) begin
                        n_live.err = 1'b1;
                    end else begin
                        n_live.v6 = 1'b1;
                        if (r_live.colons != COLON_SAT) begin
                            n_live.colons = r_live.colons + 2'd1;
                        end
                        if (r_live.prev_colon) begin
                            n_live.dc_seen = 1'b1;
                            n_live.dc_pos  = pos;
                        end
                        n_live.prev_colon = 1'b1;
                        n_live.bytes = put_byte(r_live.bytes, pos,
                                                r_live.group[GROUP_W-1:BYTE_W]);
                        if (pos == POS_W'(MAX_ADDR_BYTES - 1)) begin
                            n_live.err = 1'b1;
                        end else begin
                            n_live.bytes   = put_byte(n_live.bytes, pos + POS_W'(1),
                                                      r_live.group[BYTE_W-1:0]);
                            n_live.bw      = r_live.bw + CNT_W'(2);
                            n_live.group   = '0;
                            n_live.dec     = '0;
                            n_live.dec_bad = 1'b0;
                        end
                    end
                end
                CH_DOT: begin
                    if (r_live.v6 && !r_live.mapped && r_live.colons != COLON_SAT) begin
                        n_live.err = 1'b1;
                    end else if (r_live.dec_bad) begin
                        n_live.err = 1'b1;
                    end else begin
                        // The first dot after colons starts the dotted tail.
                        if (r_live.v6 && !r_live.mapped) begin
                            n_live.mapped = 1'b1;
                            n_live.v4_pos = pos;
                        end
                        n_live.bytes      = put_byte(r_live.bytes, pos, r_live.dec);
                        n_live.bw         = r_live.bw + CNT_W'(1);
                        n_live.prev_colon = 1'b0;
                        n_live.group      = '0;
                        n_live.dec        = '0;
                        n_live.dec_bad    = 1'b0;
                    end
                end
                CH_PCT: begin
                    if (r_live.v6 && r_live.colons == COLON_SAT) begin
                        n_live.suffix = 1'b1;
                    end else begin
                        n_live.err = 1'b1;
                    end
                end
                default: begin
                    n_live.err = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
        end else if (in_xfer) begin
            r_live <= i_in.in_last ? t_parse_state'('0) : n_live;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in.in_last) begin
            r_snap <= n_live;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (in_xfer && i_in.in_last) begin
            r_snap_valid <= 1'b1;
        end else if (frame_load) begin
            r_snap_valid <= 1'b0;
        end
    end

    // ---------------- end of string: flush group, short forms, expansion ----------------
    always_comb begin
        logic [CNT_W-1:0]  bw;
        logic [CNT_W-1:0]  tail;
        logic              v4_numbers;
        logic [POS_W-1:0]  pos;
        logic [V4_W-1:0]   low4;
        logic [1:0]        last_pos;
        logic [BYTE_W-1:0] last_byte;
        logic [CNT_W-1:0]  shift;
        logic [CNT_W-1:0]  keep_n;
        logic [ADDR_W-1:0] keep_mask;
        logic [ADDR_W-1:0] moved;

        fin_bytes  = r_snap.bytes;
        fin_bad    = r_snap.err;
        bw         = r_snap.bw;
        v4_numbers = !r_snap.v6 || r_snap.mapped;
        pos        = bw[POS_W-1:0];

        if (!fin_bad && !bw[CNT_W-1]) begin
            if (!v4_numbers) begin
                fin_bytes = put_byte(fin_bytes, pos, r_snap.group[GROUP_W-1:BYTE_W]);
                if (pos == POS_W'(MAX_ADDR_BYTES - 1)) begin
                    fin_bad = 1'b1;
                end else begin
                    fin_bytes = put_byte(fin_bytes, pos + POS_W'(1),
                                         r_snap.group[BYTE_W-1:0]);
                    bw        = bw + CNT_W'(2);
                end
            end else if (r_snap.dec_bad) begin
                fin_bad = 1'b1;
            end else begin
                fin_bytes = put_byte(fin_bytes, pos, r_snap.dec);
                bw        = bw + CNT_W'(1);
            end
        end

        // Short IPv4 form: the last number moves to the final byte.
        tail      = bw - CNT_W'(r_snap.v4_pos);
        low4      = fin_bytes[V4_W-1:0];
        last_pos  = bw[1:0] - 2'd1;
        last_byte = BYTE_W'(low4 >> (BYTE_W * last_pos));
        if (!fin_bad && v4_numbers && bw >= CNT_W'(r_snap.v4_pos)
            && tail < CNT_W'(V4_BYTES)) begin
            if (r_snap.v6 || bw == '0) begin
                fin_bad = 1'b1;
            end else begin
                low4 = low4 & ~(V4_W'({BYTE_W{1'b1}}) << (BYTE_W * last_pos));
                low4[V4_W-1:V4_W-BYTE_W] = last_byte;
                fin_bytes = ADDR_W'(low4);
                bw        = CNT_W'(V4_BYTES);
            end
        end

        // Double colon: bytes after its zero group move up to the end of the address.
        shift     = CNT_W'(MAX_ADDR_BYTES) - bw;
        keep_n    = CNT_W'(r_snap.dc_pos) + CNT_W'(2);
        keep_mask = ~({ADDR_W{1'b1}} << (BYTE_W * keep_n));
        moved     = (fin_bytes & ~keep_mask) << (BYTE_W * shift);
        if (!fin_bad && r_snap.v6 && r_snap.dc_seen && !bw[CNT_W-1]) begin
            fin_bytes = (fin_bytes & keep_mask) | moved;
            bw        = CNT_W'(MAX_ADDR_BYTES);
        end

        if (bw != (r_snap.v6 ? CNT_W'(MAX_ADDR_BYTES) : CNT_W'(V4_BYTES))) begin
            fin_bad = 1'b1;
        end
    end

    // ---------------- result frame ----------------
    assign out_xfer   = o_out.valid && o_out.ready;
    assign out_done   = out_xfer && o_out.out_last;
    assign frame_load = r_snap_valid && (!r_frame_valid || out_done);

    assign o_out.valid       = r_frame_valid;
    assign o_out.out_byte    = r_frame_bytes[BYTE_W-1:0];
    assign o_out.byte_index  = r_out_idx;
    assign o_out.is_ipv6     = r_out_v6;
    assign o_out.bad_address = r_out_bad;
    assign o_out.out_last    = r_out_bad
        || (r_out_idx == (r_out_v6 ? IDX_W'(MAX_ADDR_BYTES - 1) : IDX_W'(V4_BYTES - 1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_valid <= 1'b0;
        end else if (frame_load) begin
            r_frame_valid <= 1'b1;
        end else if (out_done) begin
            r_frame_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_load) begin
            r_frame_bytes <= fin_bad ? '0 : fin_bytes;
            r_out_idx     <= '0;
            r_out_v6      <= !fin_bad && r_snap.v6;
            r_out_bad     <= fin_bad;
        end else if (out_xfer) begin
            r_frame_bytes <= r_frame_bytes >> BYTE_W;
            r_out_idx     <= r_out_idx + IDX_W'(1);
        end
    end

endmodule
